// File: hw/rtl/cver_pkg.sv
// ----------------------------------------------------------------------------
// cver_pkg: shared types and constants of the condition vector event recorder
// Action and status codes, the input item, the log entry and the result
// record passed between the core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cver_pkg;

  // Default store depth
  localparam int unsigned LOG_DEPTH_DEF = 256;

  // Fixed field widths
  localparam int unsigned LIMIT_W   = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // Largest legal condition count
  localparam logic [5:0] COND_MAX = 6'd62;

  // Reset value of the entry limit register
  localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RST = 9'd256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_KEY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 1'd1;

  // Action codes
  typedef enum logic [2:0] {
    ACT_RECORD = 3'd0,
    ACT_SEAL   = 3'd1,
    ACT_READ   = 3'd2,
    ACT_START  = 3'd3,
    ACT_DISARM = 3'd4
  } action_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_UNARMED  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_PHASE    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // One command as captured at the input register
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] session;
    logic [31:0] decision;
    logic [5:0]  cond_total;
    logic [63:0] evaluated_bits;
    logic [63:0] true_bits;
    logic [63:0] owner;
    logic [63:0] owner_seq;
    logic        outcome_in;
    logic [7:0]  read_index;
  } item_t;

  // One log entry as held in the store
  typedef struct packed {
    logic [31:0] decision;
    logic [5:0]  cond_total;
    logic [63:0] evaluated;
    logic [63:0] true_bits;
    logic [63:0] owner;
    logic [63:0] owner_seq;
    logic        outcome;
  } entry_t;

  // Result record from the core; read_ok selects the store read data
  typedef struct packed {
    status_t              status;
    logic                 read_ok;
    logic [LIMIT_W-1:0]   fill;
    logic [63:0]          first_lost;
    logic [63:0]          lost_total;
    logic                 lost_flag;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/cver_ram.sv
// ----------------------------------------------------------------------------
// cver_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cver_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/cver_core.sv
// ----------------------------------------------------------------------------
// cver_core: command decode, checks and recorder state
// Applies one captured command per cycle: validates records, appends to the
// log, tracks sequence and loss counters, and registers the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module cver_core #(
  parameter int unsigned LOG_DEPTH = cver_pkg::LOG_DEPTH_DEF,
  localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration writes
  input  wire logic                              wr_en,
  input  wire logic [cver_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [63:0]                       wr_data,
  // captured command
  input  wire logic                              in_valid,
  input  wire cver_pkg::item_t                   in_item,
  // log store ports
  output logic                                   log_we,
  output logic [AW-1:0]                          log_waddr,
  output cver_pkg::entry_t                       log_wdata,
  output logic [AW-1:0]                          log_raddr,
  // registered result
  output logic                                   res_valid,
  output cver_pkg::result_t                      res
);

  localparam int unsigned LW = cver_pkg::LIMIT_W;
  localparam int unsigned DW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned EW = LW + DW;
  localparam logic [EW-1:0] DEPTH_X = EW'(LOG_DEPTH);

  // Configuration registers
  logic [63:0]   session_key;
  logic [LW-1:0] entry_limit;

  // Recorder state
  logic [LW-1:0] fill,        fill_next;
  logic [63:0]   next_seq,    next_seq_next;
  logic [63:0]   first_lost,  first_lost_next;
  logic [63:0]   lost_total,  lost_total_next;
  logic          lost_flag,   lost_flag_next;
  logic          sealed,      sealed_next;
  logic          armed,       armed_next;
  logic [63:0]   held_session, held_session_next;
  logic [LW-1:0] held_limit,  held_limit_next;

  cver_pkg::result_t res_next;

  // Working signals
  logic [63:0]   allowed;
  logic          fields_ok;
  logic          full;
  logic          lose;
  logic [63:0]   lose_seq;
  logic [EW-1:0] fill_x;
  logic [EW-1:0] held_x;
  logic [EW-1:0] limit_x;
  logic [EW-1:0] idx_x;
  logic [AW+LW-1:0] waddr_w;
  logic [AW+7:0]    raddr_w;

  // Widened views for compares and address slicing
  assign fill_x  = {{DW{1'b0}}, fill};
  assign held_x  = {{DW{1'b0}}, held_limit};
  assign limit_x = {{DW{1'b0}}, entry_limit};
  assign idx_x   = {{(EW-8){1'b0}}, in_item.read_index};
  assign waddr_w = {{AW{1'b0}}, fill};
  assign raddr_w = {{AW{1'b0}}, in_item.read_index};

  assign log_waddr = waddr_w[AW-1:0];
  assign log_raddr = raddr_w[AW-1:0];

  // Entry as it would be appended
  assign log_wdata = '{
    decision:   in_item.decision,
    cond_total: in_item.cond_total,
    evaluated:  in_item.evaluated_bits,
    true_bits:  in_item.true_bits,
    owner:      in_item.owner,
    owner_seq:  in_item.owner_seq,
    outcome:    in_item.outcome_in
  };

  // Record field checks
  assign allowed   = ~({64{1'b1}} << in_item.cond_total);
  assign fields_ok = (in_item.session != '0) && (in_item.decision != '0) &&
                     (in_item.cond_total != '0) &&
                     (in_item.cond_total <= cver_pkg::COND_MAX) &&
                     (in_item.owner != '0) &&
                     ((in_item.evaluated_bits & ~allowed) == '0) &&
                     ((in_item.true_bits & ~in_item.evaluated_bits) == '0);
  assign full = (fill_x >= held_x) || (fill_x >= DEPTH_X);

  // Command decode and state update
  always_comb begin
    fill_next         = fill;
    next_seq_next     = next_seq;
    first_lost_next   = first_lost;
    lost_total_next   = lost_total;
    lost_flag_next    = lost_flag;
    sealed_next       = sealed;
    armed_next        = armed;
    held_session_next = held_session;
    held_limit_next   = held_limit;
    log_we            = 1'b0;
    lose              = 1'b0;
    lose_seq          = next_seq;
    res_next.status   = cver_pkg::ST_INVALID;
    res_next.read_ok  = 1'b0;

    if (in_valid) begin
      unique case (in_item.action)
        cver_pkg::ACT_RECORD: begin
          if (!fields_ok) begin
            res_next.status = cver_pkg::ST_INVALID;
          end else if (!armed) begin
            res_next.status = cver_pkg::ST_UNARMED;
          end else if (held_session != in_item.session) begin
            res_next.status = cver_pkg::ST_MISMATCH;
          end else if (sealed) begin
            res_next.status = cver_pkg::ST_PHASE;
          end else if (next_seq == '1) begin
            // sequence space used up: drop without taking a number
            lose            = 1'b1;
            res_next.status = cver_pkg::ST_OVERFLOW;
          end else begin
            next_seq_next = next_seq + 64'd1;
            if (full) begin
              lose            = 1'b1;
              res_next.status = cver_pkg::ST_OVERFLOW;
            end else begin
              log_we          = 1'b1;
              fill_next       = fill + LW'(1);
              res_next.status = cver_pkg::ST_OK;
            end
          end
        end
        cver_pkg::ACT_SEAL: begin
          if (!armed) begin
            res_next.status = cver_pkg::ST_UNARMED;
          end else if (held_session != in_item.session) begin
            res_next.status = cver_pkg::ST_MISMATCH;
          end else begin
            sealed_next     = 1'b1;
            res_next.status = cver_pkg::ST_OK;
          end
        end
        cver_pkg::ACT_READ: begin
          if (!armed) begin
            res_next.status = cver_pkg::ST_UNARMED;
          end else if (!sealed) begin
            res_next.status = cver_pkg::ST_PHASE;
          end else if (idx_x >= fill_x) begin
            res_next.status = cver_pkg::ST_INVALID;
          end else begin
            res_next.status  = cver_pkg::ST_OK;
            res_next.read_ok = 1'b1;
          end
        end
        cver_pkg::ACT_START: begin
          if ((session_key == '0) || (entry_limit == '0)) begin
            res_next.status = cver_pkg::ST_INVALID;
          end else begin
            fill_next         = '0;
            next_seq_next     = '0;
            first_lost_next   = '1;
            lost_total_next   = '0;
            lost_flag_next    = 1'b0;
            sealed_next       = 1'b0;
            held_session_next = session_key;
            held_limit_next   = (limit_x > DEPTH_X) ? DEPTH_X[LW-1:0] : entry_limit;
            armed_next        = 1'b1;
            res_next.status   = cver_pkg::ST_OK;
          end
        end
        cver_pkg::ACT_DISARM: begin
          fill_next         = '0;
          next_seq_next     = '0;
          first_lost_next   = '1;
          lost_total_next   = '0;
          lost_flag_next    = 1'b0;
          sealed_next       = 1'b0;
          held_session_next = '0;
          held_limit_next   = '0;
          armed_next        = 1'b0;
          res_next.status   = cver_pkg::ST_OK;
        end
        default: begin
          res_next.status = cver_pkg::ST_INVALID;
        end
      endcase
    end

    // Loss bookkeeping: first lost sequence is sticky, count saturates
    if (lose) begin
      if (!lost_flag) begin
        first_lost_next = lose_seq;
      end
      lost_flag_next = 1'b1;
      if (lost_total != '1) begin
        lost_total_next = lost_total + 64'd1;
      end
    end

    res_next.fill       = fill_next;
    res_next.first_lost = first_lost_next;
    res_next.lost_total = lost_total_next;
    res_next.lost_flag  = lost_flag_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      session_key <= '0;
      entry_limit <= cver_pkg::ENTRY_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        cver_pkg::CFG_SESSION_KEY: session_key <= wr_data;
        cver_pkg::CFG_ENTRY_LIMIT: entry_limit <= wr_data[LW-1:0];
      endcase
    end
  end

  // Recorder state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      next_seq     <= '0;
      first_lost   <= '1;
      lost_total   <= '0;
      lost_flag    <= 1'b0;
      sealed       <= 1'b0;
      armed        <= 1'b0;
      held_session <= '0;
      held_limit   <= '0;
      res_valid    <= 1'b0;
    end else begin
      fill         <= fill_next;
      next_seq     <= next_seq_next;
      first_lost   <= first_lost_next;
      lost_total   <= lost_total_next;
      lost_flag    <= lost_flag_next;
      sealed       <= sealed_next;
      armed        <= armed_next;
      held_session <= held_session_next;
      held_limit   <= held_limit_next;
      res_valid    <= in_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // Fill never passes the latched limit
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= held_limit)
    else $error("fill level above latched limit");

  // Appends only while armed and open
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    log_we |-> (armed && !sealed && in_valid))
    else $error("log write outside open session");

  // No loss recorded means clean loss counters
  a_loss_clean: assert property (@(posedge clk) disable iff (rst)
    !lost_flag |-> ((lost_total == '0) && (first_lost == '1)))
    else $error("loss counters set without loss flag");

  // Every captured command yields one result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> res_valid)
    else $error("command without result");

endmodule

`default_nettype wire

// File: hw/rtl/condition_vector_event_recorder.sv
// ----------------------------------------------------------------------------
// condition_vector_event_recorder: session-tagged event recorder
// Input register, decode/state core, log store and result drive.
//
//  Channel   Handshake          Payload
//  command   start / busy       action, session, decision, cond_total,
//                               evaluated_bits, true_bits, owner, owner_seq,
//                               outcome_in, read_index
//  result    done (one cycle)   status, out_*, stored_count, first_lost,
//                               lost_count, overflow_flag
//  config    wr_en              wr_index, wr_data
//
//  One command per cycle; the input register loads at the transfer edge,
//  done rises in the cycle after that (core and store read register) and
//  the result is taken while done is high.
//  busy is high only during reset; outside reset every start is taken.
//  Reset is synchronous and needs no clearing pass: the log is read only
//  below the fill level.
//  The receiver cannot stall; done lasts exactly one cycle per command.
// ----------------------------------------------------------------------------
`default_nettype none

module condition_vector_event_recorder #(
  parameter int unsigned LOG_DEPTH = cver_pkg::LOG_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            wr_en,
  input  wire logic [cver_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [63:0]                     wr_data,
  // command
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [2:0]                      action,
  input  wire logic [63:0]                     session,
  input  wire logic [31:0]                     decision,
  input  wire logic [5:0]                      cond_total,
  input  wire logic [63:0]                     evaluated_bits,
  input  wire logic [63:0]                     true_bits,
  input  wire logic [63:0]                     owner,
  input  wire logic [63:0]                     owner_seq,
  input  wire logic                            outcome_in,
  input  wire logic [7:0]                      read_index,
  // result
  output logic                                 done,
  output logic [2:0]                           status,
  output logic [31:0]                          out_decision,
  output logic [5:0]                           out_cond_total,
  output logic [63:0]                          out_evaluated,
  output logic [63:0]                          out_true,
  output logic [63:0]                          out_owner,
  output logic [63:0]                          out_owner_seq,
  output logic                                 out_outcome,
  output logic [8:0]                           stored_count,
  output logic [63:0]                          first_lost,
  output logic [63:0]                          lost_count,
  output logic                                 overflow_flag
);

  localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int unsigned EWIDTH = $bits(cver_pkg::entry_t);

  logic              in_valid;
  cver_pkg::item_t   in_item;
  logic              log_we;
  logic [AW-1:0]     log_waddr;
  logic [AW-1:0]     log_raddr;
  cver_pkg::entry_t  log_wdata;
  logic [EWIDTH-1:0] log_rdata;
  cver_pkg::entry_t  rd_entry;
  logic              res_valid;
  cver_pkg::result_t res;

  assign busy = rst;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_item <= '{
      action:         action,
      session:        session,
      decision:       decision,
      cond_total:     cond_total,
      evaluated_bits: evaluated_bits,
      true_bits:      true_bits,
      owner:          owner,
      owner_seq:      owner_seq,
      outcome_in:     outcome_in,
      read_index:     read_index
    };
  end

  // Decode and state
  cver_core #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .log_we    (log_we),
    .log_waddr (log_waddr),
    .log_wdata (log_wdata),
    .log_raddr (log_raddr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Log store
  cver_ram #(
    .WIDTH (EWIDTH),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  assign rd_entry = cver_pkg::entry_t'(log_rdata);

  // Result drive; entry fields are zero unless the read succeeded
  assign done           = res_valid;
  assign status         = res.status;
  assign out_decision   = res.read_ok ? rd_entry.decision   : '0;
  assign out_cond_total = res.read_ok ? rd_entry.cond_total : '0;
  assign out_evaluated  = res.read_ok ? rd_entry.evaluated  : '0;
  assign out_true       = res.read_ok ? rd_entry.true_bits  : '0;
  assign out_owner      = res.read_ok ? rd_entry.owner      : '0;
  assign out_owner_seq  = res.read_ok ? rd_entry.owner_seq  : '0;
  assign out_outcome    = res.read_ok ? rd_entry.outcome    : 1'b0;
  assign stored_count   = res.fill;
  assign first_lost     = res.first_lost;
  assign lost_count     = res.lost_total;
  assign overflow_flag  = res.lost_flag;

endmodule

`default_nettype wire
